// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, nxt)
`endif
`endif

// ----- rtl/core/tss_pkg.sv -----
// Types, codes and constants of the TDMA slot scheduler.
// Used by the controller, the datapath and the top level.
package tss_pkg;

   localparam int T_W           = 52;
   localparam int DAY_W         = 37;
   localparam int MAX_SLOTS_DEF = 32;
   localparam int CSR_IDX_W     = 3;

   localparam logic [DAY_W-1:0] US_PER_DAY   = 37'd86400000000;
   localparam logic [7:0]       BCAST_SRC    = 8'd0;
   localparam logic [31:0]      SKEW_RESET   = 32'd1000000;

   // day remainder: day count estimated from the top time bits, then corrected
   localparam int                   DAY_SH    = 33;
   localparam int                   DAY_RCP_W = 21;
   localparam int                   DAY_Q_W   = 16;
   localparam logic [DAY_RCP_W-1:0] DAY_RCP   = 21'd1667999;  // floor(2^57 / day)

   // action codes
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_LOAD  = 3'd1;
   localparam logic [2:0] ACT_CLEAR = 3'd2;
   localparam logic [2:0] ACT_START = 3'd3;
   localparam logic [2:0] ACT_STOP  = 3'd4;

   // mac types
   localparam logic [1:0] MAC_NONE    = 2'd0;
   localparam logic [1:0] MAC_CENTRAL = 2'd1;
   localparam logic [1:0] MAC_DECENT  = 2'd2;
   localparam logic [1:0] MAC_RSVD    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAC_TYPE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_REF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SKEW      = 3'd5;

   typedef struct packed {
      logic [2:0]     action;
      logic [T_W-1:0] now_us;
      logic [7:0]     slot_src;
      logic [7:0]     slot_dest;
      logic           slot_always_initiate;
      logic [31:0]    slot_duration_us;
   } req_type;

   typedef struct packed {
      logic           slot_started;
      logic           transmit;
      logic [4:0]     slot_index;
      logic [7:0]     slot_src_out;
      logic [7:0]     slot_dest_out;
      logic [T_W-1:0] slot_start_us;
      logic           resynced;
      logic           running;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  src;
      logic [7:0]  dest;
      logic        always_init;
      logic [31:0] duration;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic load_slot;
      logic clear_tbl;
      logic stop;
      logic set_rs;
      logic clr_active;
      logic align_init;
      logic day_step;
      logic div_step;
      logic div_reload;
      logic align_fin;
      logic walk_step;
      logic tick_emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] action;
      logic       tick_due;
      logic       tick_late;
      logic       cur_valid;
      logic       full;
      logic       mac12;
      logic       active;
      logic       empty;
      logic       ref_fixed;
      logic       day_last;
      logic       div_last;
      logic       walk_en;
      logic       walk_go;
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_REALIGN,
      S_DIV_DAY,
      S_DIV_CYC,
      S_ALIGN,
      S_WALK_CHECK,
      S_WALK_ADD,
      S_TICK_EMIT,
      S_RESPOND
   } state_type;

endpackage

// ----- rtl/core/tdma_slot_scheduler.sv -----
// TDMA slot scheduler top level: controller, datapath and slot table RAM.
// Depends on tss_pkg, tss_ram, tss_ctrl and tss_dpath.
//
//  channel  ports                               transfer when
//  request  start, busy, req_data               start high, busy low
//  result   rsp_strobe, rsp_data                rsp_strobe high (one cycle)
//  config   csr_valid, csr_ready, csr_index,    csr_valid and csr_ready high
//           csr_wdata
//
// Load, clear and stop pass from decode straight to the result; a tick that
// emits passes through an emit state first. Realignment runs a one-bit-per-cycle
// remainder divider over the 52-bit dividend, after a day reduction when aligned
// to the day start, then an align step, plus a check and an add per slot skipped.
// Reset is synchronous and clears the table fill count and schedule and
// restores the register defaults. busy stays high until the result strobe;
// the receiver cannot stall.
module tdma_slot_scheduler import tss_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [T_W-1:0]       csr_wdata
);
   localparam int IW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;

   cmd_type   cmd;
   stat_type  stat;
   logic      ram_we;
   logic [IW-1:0] ram_waddr;
   logic [IW-1:0] ram_raddr;
   entry_type ram_wdata;
   entry_type ram_rdata;

   tss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   tss_dpath #(.MAX_SLOTS(MAX_SLOTS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   tss_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_SLOTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );
endmodule

// ----- rtl/core/tss_ram.sv -----
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
module tss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and read one word each cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/tss_ctrl.sv -----
// Sequencer of the slot scheduler: decodes an item and steps the datapath.
// Depends on tss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tss_ctrl import tss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_strobe,
   output cmd_type  cmd,
   input  stat_type stat
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_TICK: begin
                  if (!stat.tick_due) state_in = S_RESPOND;
                  else if (stat.tick_late || !stat.cur_valid) state_in = S_REALIGN;
                  else state_in = S_TICK_EMIT;
               end
               ACT_START: begin
                  if (stat.mac12 && !stat.active) state_in = S_REALIGN;
                  else state_in = S_RESPOND;
               end
               default: state_in = S_RESPOND;
            endcase
         end
         S_REALIGN: begin
            if (stat.empty) state_in = S_RESPOND;
            else if (stat.ref_fixed) state_in = S_DIV_CYC;
            else state_in = S_DIV_DAY;
         end
         S_DIV_DAY: begin
            if (stat.day_last) state_in = S_DIV_CYC;
         end
         S_DIV_CYC: begin
            if (stat.div_last) state_in = S_ALIGN;
         end
         S_ALIGN: begin
            state_in = stat.walk_en ? S_WALK_CHECK : S_RESPOND;
         end
         S_WALK_CHECK: begin
            state_in = stat.walk_go ? S_WALK_ADD : S_RESPOND;
         end
         S_WALK_ADD:  state_in = S_WALK_CHECK;
         S_TICK_EMIT: state_in = S_RESPOND;
         S_RESPOND:   state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_TICK: begin
                  cmd.set_rs = stat.tick_due && (stat.tick_late || !stat.cur_valid);
               end
               ACT_LOAD:  cmd.load_slot = !stat.full;
               ACT_CLEAR: cmd.clear_tbl = 1'b1;
               ACT_STOP:  cmd.stop      = 1'b1;
               default: ;
            endcase
         end
         S_REALIGN: begin
            cmd.clr_active = stat.empty;
            cmd.align_init = !stat.empty;
         end
         S_DIV_DAY: begin
            cmd.day_step   = 1'b1;
            cmd.div_reload = stat.day_last;
         end
         S_DIV_CYC:   cmd.div_step  = 1'b1;
         S_ALIGN:     cmd.align_fin = 1'b1;
         S_WALK_ADD:  cmd.walk_step = 1'b1;
         S_TICK_EMIT: cmd.tick_emit = 1'b1;
         S_RESPOND:   rsp_strobe    = 1'b1;
         default: ;
      endcase
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_AT(a_strobe_busy, clock, reset, !rsp_strobe || busy)
   `ASSERT_NEXT(a_strobe_ends, clock, reset, rsp_strobe, !busy && !rsp_strobe)
endmodule

// ----- rtl/core/tss_dpath.sv -----
// Datapath of the slot scheduler: registers, slot timing, remainder divider.
// Depends on tss_pkg and assert_macros.svh; the slot table is an external RAM.
`include "assert_macros.svh"
module tss_dpath import tss_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  req_type                              req_data,
   input  cmd_type                              cmd,
   output stat_type                             stat,
   output rsp_type                              rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [CSR_IDX_W-1:0]                 csr_index,
   input  logic [T_W-1:0]                       csr_wdata,
   output logic                                 ram_we,
   output logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] ram_waddr,
   output entry_type                            ram_wdata,
   output logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] ram_raddr,
   input  entry_type                            ram_rdata
);
   localparam int IW  = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
   localparam int CNW = $clog2(MAX_SLOTS + 1);
   localparam int CW  = $clog2(MAX_SLOTS) + 32;
   localparam int DW  = CW > DAY_W ? CW : DAY_W;
   localparam int DCW = $clog2(T_W);
   localparam int DPW = T_W - DAY_SH + DAY_RCP_W;
   localparam int DBW = DAY_Q_W + DAY_W;

   // configuration
   logic [1:0]     mac_ff;
   logic [7:0]     own_ff;
   logic           mid_ff;
   logic           refm_ff;
   logic [T_W-1:0] fref_ff;
   logic [31:0]    skew_ff;

   // schedule state
   logic [CNW-1:0] count_ff, count_in;
   logic [CW-1:0]  cyc_ff, cyc_in;
   logic [IW-1:0]  cur_ff, cur_in;
   logic [T_W-1:0] nst_ff, nst_in;
   logic           active_ff, active_in;

   // item, result and divider
   req_type        req_ff, req_in;
   rsp_type        rsp_ff, rsp_in;
   logic [T_W-1:0] dvd_ff, dvd_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  dsr_ff, dsr_in;
   logic           neg_ff, neg_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [CNW-1:0] walk_ff, walk_in;
   logic [DAY_Q_W-1:0] dq_ff, dq_in;

   logic [T_W-1:0] now;
   logic           mac12;
   logic [DW:0]    trial;
   logic           ge;
   logic [DW-1:0]  rem_step;
   logic [T_W:0]   diff;
   logic [T_W:0]   negd;
   logic [T_W-1:0] base;
   logic [CNW-1:0] cur_next;
   logic [IW-1:0]  cur_wrap;
   logic [T_W-1:0] late;
   logic [DPW-1:0] day_prod;
   logic [DBW-1:0] day_back;
   logic [T_W-1:0] day_fix;

   assign now   = req_ff.now_us;
   assign mac12 = (mac_ff == MAC_CENTRAL) || (mac_ff == MAC_DECENT);

   // one remainder bit per step
   assign trial    = {rem_ff, dvd_ff[T_W-1]};
   assign ge       = trial >= {1'b0, dsr_ff};
   assign rem_step = ge ? DW'(trial - {1'b0, dsr_ff}) : DW'(trial);

   // day remainder: estimate the day count low by at most one, take it off, correct
   assign day_prod = DPW'(now[T_W-1:DAY_SH]) * DPW'(DAY_RCP);
   assign day_back = DBW'(dq_ff) * DBW'(US_PER_DAY);
   assign day_fix  = (dvd_ff >= T_W'(US_PER_DAY)) ? dvd_ff - T_W'(US_PER_DAY) : dvd_ff;

   // distance from the fixed reference, with sign
   assign diff = {1'b0, now} - {1'b0, fref_ff};
   assign negd = (T_W + 1)'(0) - diff;

   // boundary minus one cycle: now less the signed remainder
   assign base = neg_ff ? now + T_W'(rem_ff) : now - T_W'(rem_ff);

   // slot index after advance, with wrap
   assign cur_next = CNW'(cur_ff) + CNW'(1);
   assign cur_wrap = (cur_next >= count_ff) ? '0 : cur_next[IW-1:0];

   assign late = now - nst_ff;

   // status
   always_comb begin
      stat.action    = req_ff.action;
      stat.tick_due  = active_ff && (now > nst_ff);
      stat.tick_late = late > T_W'(skew_ff);
      stat.cur_valid = CNW'(cur_ff) < count_ff;
      stat.full      = count_ff >= CNW'(MAX_SLOTS);
      stat.mac12     = mac12;
      stat.active    = active_ff;
      stat.empty     = (count_ff == '0) || (cyc_ff == '0);
      stat.ref_fixed = refm_ff;
      stat.day_last  = dcnt_ff == DCW'(2);
      stat.div_last  = dcnt_ff == DCW'(T_W - 1);
      stat.walk_en   = mid_ff && (count_ff > CNW'(1)) && mac12;
      stat.walk_go   = (walk_ff < count_ff) && (nst_ff < now);
   end

   // table port: append at the fill count, read the current slot
   assign ram_we    = cmd.load_slot;
   assign ram_waddr = count_ff[IW-1:0];
   assign ram_raddr = cur_ff;
   always_comb begin
      ram_wdata.src         = req_ff.slot_src;
      ram_wdata.dest        = req_ff.slot_dest;
      ram_wdata.always_init = req_ff.slot_always_initiate;
      ram_wdata.duration    = req_ff.slot_duration_us;
   end

   // next values
   always_comb begin
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      cyc_in    = cyc_ff;
      cur_in    = cur_ff;
      nst_in    = nst_ff;
      active_in = active_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      neg_in    = neg_ff;
      dcnt_in   = dcnt_ff;
      walk_in   = walk_ff;
      dq_in     = dq_ff;

      // capture the item and clear the result
      if (cmd.accept) begin
         req_in = req_data;
         rsp_in = '0;
      end
      if (cmd.load_slot) begin
         cyc_in   = cyc_ff + CW'(req_ff.slot_duration_us);
         count_in = count_ff + CNW'(1);
      end
      if (cmd.clear_tbl) begin
         count_in  = '0;
         cyc_in    = '0;
         cur_in    = '0;
         active_in = 1'b0;
      end
      if (cmd.stop) begin
         cur_in    = '0;
         active_in = 1'b0;
      end
      if (cmd.set_rs) rsp_in.resynced = 1'b1;
      if (cmd.clr_active) active_in = 1'b0;
      // load the divider from the fixed reference, or start the day reduction
      if (cmd.align_init) begin
         active_in = 1'b1;
         cur_in    = '0;
         rem_in    = '0;
         dcnt_in   = '0;
         if (refm_ff) begin
            dvd_in = diff[T_W] ? negd[T_W-1:0] : diff[T_W-1:0];
            neg_in = diff[T_W];
            dsr_in = DW'(cyc_ff);
         end else begin
            neg_in = 1'b0;
         end
      end
      // day reduction: day count estimate, then time less whole days
      if (cmd.day_step) begin
         dcnt_in = dcnt_ff + DCW'(1);
         if (dcnt_ff == '0) begin
            dq_in = day_prod[DPW-1:DPW-DAY_Q_W];
         end else if (dcnt_ff == DCW'(1)) begin
            dvd_in = now - day_back[T_W-1:0];
         end
      end
      if (cmd.div_step) begin
         rem_in  = rem_step;
         dvd_in  = {dvd_ff[T_W-2:0], 1'b0};
         dcnt_in = dcnt_ff + DCW'(1);
      end
      // day offset becomes the dividend for the cycle length
      if (cmd.div_reload) begin
         dvd_in  = day_fix;
         neg_in  = 1'b0;
         dsr_in  = DW'(cyc_ff);
         rem_in  = '0;
         dcnt_in = '0;
      end
      if (cmd.align_fin) begin
         nst_in  = stat.walk_en ? base : base + T_W'(cyc_ff);
         walk_in = '0;
      end
      if (cmd.walk_step) begin
         nst_in  = nst_ff + T_W'(ram_rdata.duration);
         cur_in  = cur_wrap;
         walk_in = walk_ff + CNW'(1);
      end
      // emit the current slot, and advance it for the central and decentral mac types
      if (cmd.tick_emit) begin
         rsp_in.slot_started  = 1'b1;
         rsp_in.slot_index    = 5'(cur_ff);
         rsp_in.slot_src_out  = ram_rdata.src;
         rsp_in.slot_dest_out = ram_rdata.dest;
         rsp_in.slot_start_us = nst_ff;
         if (mac_ff == MAC_DECENT) begin
            rsp_in.transmit = (ram_rdata.src == own_ff) || ram_rdata.always_init;
         end else if (mac_ff == MAC_CENTRAL) begin
            rsp_in.transmit = ram_rdata.src != BCAST_SRC;
         end else begin
            rsp_in.transmit = 1'b1;
         end
         if (mac12) begin
            nst_in = nst_ff + T_W'(ram_rdata.duration);
            cur_in = cur_wrap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cyc_ff    <= '0;
         cur_ff    <= '0;
         nst_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cyc_ff    <= cyc_in;
         cur_ff    <= cur_in;
         nst_ff    <= nst_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      dcnt_ff <= dcnt_in;
      walk_ff <= walk_in;
      dq_ff   <= dq_in;
   end

   // configuration writes; unknown indexes drop
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff  <= MAC_NONE;
         own_ff  <= '0;
         mid_ff  <= 1'b0;
         refm_ff <= 1'b0;
         fref_ff <= '0;
         skew_ff <= SKEW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAC_TYPE:  mac_ff  <= csr_wdata[1:0];
            CSR_OWN_ID:    own_ff  <= csr_wdata[7:0];
            CSR_MIDDLE:    mid_ff  <= csr_wdata[0];
            CSR_REF_MODE:  refm_ff <= csr_wdata[0];
            CSR_FIXED_REF: fref_ff <= csr_wdata;
            CSR_SKEW:      skew_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_data         = rsp_ff;
      rsp_data.running = active_ff;
   end

   `ASSERT_AT(a_cur_in_table, clock, reset, !active_ff || (CNW'(cur_ff) < count_ff))
   `ASSERT_AT(a_cycle_nonzero, clock, reset, !active_ff || (cyc_ff != '0))
endmodule
